// ===== hdl/pcm_volume_pwm_duty_quantizer_unit_defines.svh =====
// Assertion macros for the PCM volume / PWM duty quantiser.
// Used by the port-level checker only; no other dependencies.
`ifndef PCM_VOLUME_PWM_DUTY_QUANTIZER_UNIT_DEFINES_SVH
`define PCM_VOLUME_PWM_DUTY_QUANTIZER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PVQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvq: same-cycle check failed");

// Next-cycle implication.
`define PVQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvq: next-cycle check failed");

`endif

// ===== hdl/pvq_pkg.sv =====
// Shared types and constants for the PCM volume / PWM duty quantiser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvq_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 16;
   localparam int DUTY_W     = 16;
   localparam int VOL_W      = 7;
   localparam int PERIOD_W   = 16;
   localparam int RESID_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd1;

   localparam logic [VOL_W-1:0]    VOLUME_RESET = 7'd80;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd128;
   localparam logic [VOL_W-1:0]    VOL_MIN      = 7'd1;
   localparam logic [VOL_W-1:0]    VOL_MAX      = 7'd100;

   // sample * volume, and its magnitude (at most 32768 * 100)
   localparam int PROD_W = 24;
   localparam int MAG_W  = 22;

   // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for all x < 2^22
   localparam int                 RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP       = 23'd5368710;
   localparam int                 RECIP_SHIFT = 29;

   localparam logic [LEVEL_W:0] LEVEL_OFFSET = 17'd32768;

   // quantiser modulus 2^16 - 1 and twice it
   localparam int              TOTAL_W    = 32;
   localparam logic [RESID_W:0] QUANT_DIV  = 17'd65535;
   localparam logic [RESID_W:0] QUANT_DIV2 = 17'd131070;

   typedef struct packed {
      logic               stream_end;
      logic [LEVEL_W-1:0] level;
   } pvq_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pvq_fifo_stat_type;

endpackage

`default_nettype wire

// ===== hdl/pcm_volume_pwm_duty_quantizer_unit.sv =====
// PCM sample to PWM compare value converter: volume, offset, error feedback.
// Top level; depends on pvq_pkg, pvq_front, pvq_fifo and pvq_back.
// Each transaction on req_ carries one signed PCM sample (or an end-of-stream
// marker) and yields exactly one rsp_ transaction with the PWM compare value.
// The sample is scaled by volume_percent (clamped to 1..100, truncated toward
// zero), offset by 32768 to an unsigned level, then mapped onto pwm_period
// with error feedback: the remainder of level*period/65535 is carried into
// the next sample. End of stream gives duty 0 and clears the remainder; a
// period of 0 gives duty 0 and keeps the remainder. The back end works on one
// transaction at a time in four states: take from the queue, multiply, add the
// remainder and reduce; it pops the next only once the result is registered.
// The front end takes a transaction every cycle until the queue is full and
// its second stage holds one, so bursts are absorbed. Registers are written
// through csr_ (index 0 volume, index 1 period; other indexes ignored); the
// user must write them only while no transaction is in flight (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module pcm_volume_pwm_duty_quantizer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample transactions
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [pvq_pkg::SAMPLE_W-1:0] req_pcm_sample,
   input  wire logic                                req_stream_end,
   // result transactions
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pvq_pkg::DUTY_W-1:0]               rsp_compare,
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pvq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pvq_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pvq_pkg::*;

   logic [VOL_W-1:0]     volume_ff, volume_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;

   logic                 push;
   logic                 pop;
   pvq_item_type         push_item;
   pvq_item_type         pop_item;
   pvq_fifo_stat_type    fifo_stat;

   // always ready: a write takes effect in the next cycle
   assign csr_ready = 1'b1;

   always_comb begin
      volume_in = volume_ff;
      period_in = period_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VOLUME: volume_in = csr_wdata[VOL_W-1:0];
            CSR_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            default: begin
               // unmapped index, dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
         period_ff <= PERIOD_RESET;
      end else begin
         volume_ff <= volume_in;
         period_ff <= period_in;
      end
   end

   // scaling and offset
   pvq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pcm_sample (req_pcm_sample),
      .req_stream_end (req_stream_end),
      .volume_percent (volume_ff),
      .fifo_stat      (fifo_stat),
      .push           (push),
      .push_item      (push_item)
   );

   // decouples the two halves
   pvq_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (fifo_stat)
   );

   // error-feedback quantiser and result register
   pvq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pwm_period     (period_ff),
      .fifo_stat      (fifo_stat),
      .pop_item       (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_compare    (rsp_compare)
   );

endmodule

`default_nettype wire

// ===== hdl/pvq_front.sv =====
// Front end: accepts samples, applies volume and level offset.
// Depends on pvq_pkg; feeds pvq_fifo.
`timescale 1ns / 1ps
`default_nettype none

module pvq_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [pvq_pkg::SAMPLE_W-1:0] req_pcm_sample,
   input  wire logic                            req_stream_end,
   input  wire logic [pvq_pkg::VOL_W-1:0]       volume_percent,
   input  wire pvq_pkg::pvq_fifo_stat_type      fifo_stat,
   output logic                                 push,
   output pvq_pkg::pvq_item_type                push_item
);
   import pvq_pkg::*;

   logic                        advance;
   logic [VOL_W-1:0]            vol_eff;
   logic [PROD_W-1:0]           abs_full;
   logic [MAG_W-1:0]            mag;
   logic [MAG_W+RECIP_W-1:0]    recip_prod;
   logic [LEVEL_W:0]            level_wide;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_end_ff, s1_end_in;
   logic signed [PROD_W-1:0]    s1_prod_ff, s1_prod_in;
   logic                        s2_valid_ff, s2_valid_in;
   logic                        s2_end_ff, s2_end_in;
   logic                        s2_neg_ff, s2_neg_in;
   logic [LEVEL_W-1:0]          s2_quot_ff, s2_quot_in;

   assign advance   = !s2_valid_ff || !fifo_stat.full;
   assign req_stall = reset || !advance;
   assign push      = s2_valid_ff && !fifo_stat.full;

   // clamp volume to 1..100
   always_comb begin
      if (volume_percent < VOL_MIN) begin
         vol_eff = VOL_MIN;
      end else if (volume_percent > VOL_MAX) begin
         vol_eff = VOL_MAX;
      end else begin
         vol_eff = volume_percent;
      end
   end

   assign abs_full   = s1_prod_ff[PROD_W-1] ? (~s1_prod_ff + PROD_W'(1)) : s1_prod_ff;
   assign mag        = abs_full[MAG_W-1:0];
   assign recip_prod = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(RECIP);

   // truncation toward zero: divide the magnitude, restore the sign
   assign level_wide = s2_neg_ff ? (LEVEL_OFFSET - {1'b0, s2_quot_ff})
                                 : (LEVEL_OFFSET + {1'b0, s2_quot_ff});
   assign push_item.stream_end = s2_end_ff;
   assign push_item.level      = level_wide[LEVEL_W-1:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_end_in   = s1_end_ff;
      s1_prod_in  = s1_prod_ff;
      s2_valid_in = s2_valid_ff;
      s2_end_in   = s2_end_ff;
      s2_neg_in   = s2_neg_ff;
      s2_quot_in  = s2_quot_ff;
      if (advance) begin
         s1_valid_in = req_valid;
         s1_end_in   = req_stream_end;
         // both operands widened (signed) before the multiply
         s1_prod_in  = PROD_W'(req_pcm_sample) * PROD_W'($signed({1'b0, vol_eff}));
         s2_valid_in = s1_valid_ff;
         s2_end_in   = s1_end_ff;
         s2_neg_in   = s1_prod_ff[PROD_W-1];
         s2_quot_in  = recip_prod[RECIP_SHIFT +: LEVEL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_end_ff  <= s1_end_in;
      s1_prod_ff <= s1_prod_in;
      s2_end_ff  <= s2_end_in;
      s2_neg_ff  <= s2_neg_in;
      s2_quot_ff <= s2_quot_in;
   end

endmodule

`default_nettype wire

// ===== hdl/pvq_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on pvq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvq_fifo #(
   parameter int DEPTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire pvq_pkg::pvq_item_type       push_item,
   input  wire logic                        pop,
   output pvq_pkg::pvq_item_type            pop_item,
   output pvq_pkg::pvq_fifo_stat_type       stat
);
   import pvq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pvq_item_type      entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pvq_back.sv =====
// Back end: error-feedback quantiser onto the PWM period, result register.
// Depends on pvq_pkg; drained from pvq_fifo.
`timescale 1ns / 1ps
`default_nettype none

module pvq_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [pvq_pkg::PERIOD_W-1:0] pwm_period,
   input  wire pvq_pkg::pvq_fifo_stat_type   fifo_stat,
   input  wire pvq_pkg::pvq_item_type        pop_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [pvq_pkg::DUTY_W-1:0]        rsp_compare
);
   import pvq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_DIV  = 4'b1000
   } back_state_type;

   back_state_type      state_ff, state_in;
   pvq_item_type        item_ff, item_in;
   logic [TOTAL_W-1:0]  prod_ff, prod_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [RESID_W-1:0]  resid_ff, resid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;

   logic [RESID_W-1:0]  hi;
   logic [RESID_W:0]    fold;
   logic [DUTY_W-1:0]   duty_calc;
   logic [RESID_W-1:0]  rem_calc;
   logic [RESID_W:0]    rem_wide;
   logic                out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_compare    = duty_ff;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign pop            = (state_ff == ST_IDLE) && !fifo_stat.empty;

   // total mod (2^16-1): 2^16 is 1 modulo the divisor, so fold the halves
   assign hi   = total_ff[TOTAL_W-1 -: RESID_W];
   assign fold = {1'b0, total_ff[RESID_W-1:0]} + {1'b0, hi};

   always_comb begin
      rem_wide  = fold;
      duty_calc = hi;
      priority if (fold >= QUANT_DIV2) begin
         rem_wide  = fold - QUANT_DIV2;
         duty_calc = hi + DUTY_W'(2);
      end else if (fold >= QUANT_DIV) begin
         rem_wide  = fold - QUANT_DIV;
         duty_calc = hi + DUTY_W'(1);
      end
      rem_calc = rem_wide[RESID_W-1:0];
      if (item_ff.stream_end) begin
         duty_calc = '0;
         rem_calc  = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      resid_in     = resid_ff;
      duty_in      = duty_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_stat.empty) begin
               item_in  = pop_item;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = TOTAL_W'(item_ff.level) * TOTAL_W'(pwm_period);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            total_in = prod_ff + TOTAL_W'(resid_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (out_free) begin
               duty_in      = duty_calc;
               resid_in     = rem_calc;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resid_ff     <= resid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      prod_ff  <= prod_in;
      total_ff <= total_in;
      duty_ff  <= duty_in;
   end

endmodule

`default_nettype wire

// ===== hdl/pvq_checker.sv =====
// Port-level checker for the quantiser top level, with its bind.
// Depends on pcm_volume_pwm_duty_quantizer_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pcm_volume_pwm_duty_quantizer_unit_defines.svh"

module pvq_checker #(
   parameter int QUEUE_DEPTH = 2
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [pvq_pkg::DUTY_W-1:0]   rsp_compare
);

   // two front stages, the queue, the back end and the result register
   localparam int MAX_PEND = QUEUE_DEPTH + 4;
   localparam int PEND_W   = $clog2(MAX_PEND + 2);

   logic              req_take;
   logic              rsp_take;
   logic              rsp_held;
   logic [PEND_W-1:0] pending_ff, pending_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + PEND_W'(1);
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `PVQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_compare))
   `PVQ_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `PVQ_ASSERT_NOW(a_no_spurious_rsp, clock, reset, rsp_valid, pending_ff != '0)
   `PVQ_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1, pending_ff <= PEND_W'(MAX_PEND))

endmodule

bind pcm_volume_pwm_duty_quantizer_unit pvq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pvq_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_pcm_volume_pwm_duty_quantizer_unit.sv =====
// Self-checking testbench for the PCM volume / PWM duty quantiser.
// Predicts duty values with error feedback and checks every rsp_ transaction.
// Depends on pvq_pkg and pcm_volume_pwm_duty_quantizer_unit only.
`timescale 1ns / 1ps

module tb_pcm_volume_pwm_duty_quantizer_unit;

   import pvq_pkg::*;

   localparam int          DRAIN_CYCLES    = 12;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          PERCENT_FULL    = 100;
   localparam int          LEVEL_BIAS      = 32768;
   localparam longint      QUANT_MOD       = 65535;
   localparam longint      LIMIT_NS        = 800000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_W-1:0]     req_pcm_sample = '0;
   logic                           req_stream_end = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [DUTY_W-1:0]              rsp_compare;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_IDX_W-1:0]           csr_index = '0;
   logic [CSR_DATA_W-1:0]          csr_wdata = '0;

   // predictor state
   logic [VOL_W-1:0]               gain_setting      = VOLUME_RESET;
   logic [PERIOD_W-1:0]            carrier_period    = PERIOD_RESET;
   logic [RESID_W-1:0]             carried_remainder = '0;

   logic [DUTY_W-1:0]              expected_duty[$];
   logic [DUTY_W-1:0]              oldest_duty;
   int unsigned                    error_count   = 0;
   int unsigned                    send_idle_pct = 0;
   int unsigned                    rsp_stall_pct = 0;
   int unsigned                    hold_left     = 0;
   bit                             hold_request  = 1'b0;

   pcm_volume_pwm_duty_quantizer_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pcm_sample (req_pcm_sample),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_compare    (rsp_compare),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Expected duty for one sample transaction; advances the carried remainder.
   function automatic logic [DUTY_W-1:0] predict_duty(input logic signed [SAMPLE_W-1:0] sample,
                                                      input logic end_flag);
      int              gain;
      int              scaled;
      longint unsigned level;
      longint unsigned total;
      if (end_flag) begin
         carried_remainder = '0;
         return '0;
      end
      gain = int'(gain_setting);
      if (gain < int'(VOL_MIN)) gain = int'(VOL_MIN);
      if (gain > int'(VOL_MAX)) gain = int'(VOL_MAX);
      scaled = (int'(sample) * gain) / PERCENT_FULL;   // truncates toward zero
      level  = longint'(scaled + LEVEL_BIAS);
      // a zero period falls out naturally: duty 0, remainder kept
      total  = level * longint'(carrier_period) + longint'(carried_remainder);
      carried_remainder = RESID_W'(total % QUANT_MOD);
      return DUTY_W'(total / QUANT_MOD);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Result checker: one expectation consumed per accepted rsp_ transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_duty.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, compare %0d", rsp_compare));
         end else begin
            oldest_duty = expected_duty.pop_front();
            if (rsp_compare !== oldest_duty)
               report_mismatch($sformatf("compare %0d, expected %0d",
                                         rsp_compare, oldest_duty));
         end
      end
   end

   // Receiver stall: random per cycle, or a long hold-off when requested.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Offer one transaction, hold it until taken, then maybe leave idle cycles.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input logic end_flag);
      req_valid      <= 1'b1;
      req_pcm_sample <= sample;
      req_stream_end <= end_flag;
      do @(posedge clock); while (req_stall);
      expected_duty.push_back(predict_duty(sample, end_flag));
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_pcm_sample <= SAMPLE_W'($urandom);
         req_stream_end <= 1'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_random_item();
      logic signed [SAMPLE_W-1:0] sample;
      logic                       end_flag;
      sample   = SAMPLE_W'($urandom);
      end_flag = ($urandom_range(99) < 4);
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0:       sample = 16'sh8000;
            1:       sample = 16'sh7fff;
            2:       sample = 16'sh0000;
            default: sample = 16'shffff;
         endcase
      end
      send_sample(sample, end_flag);
   endtask

   // Wait until nothing is in flight.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_duty.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      quiesce();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_VOLUME: gain_setting   = data[VOL_W-1:0];
         CSR_PERIOD: carrier_period = data[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // Volume writes carry junk in the upper bits, which the register drops.
   task automatic set_gain(input int unsigned gain);
      write_register(CSR_VOLUME, {9'($urandom), VOL_W'(gain)});
   endtask

   task automatic pick_random_settings();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0:       set_gain(0);
         1:       set_gain($urandom_range(101, 127));
         2:       set_gain(PERCENT_FULL);
         default: set_gain($urandom_range(1, PERCENT_FULL));
      endcase
      pick = $urandom_range(11);
      case (pick)
         0:       write_register(CSR_PERIOD, 16'd0);
         1:       write_register(CSR_PERIOD, 16'd1);
         2:       write_register(CSR_PERIOD, 16'hffff);
         3, 4:    write_register(CSR_PERIOD, 16'($urandom_range(2, 255)));
         default: write_register(CSR_PERIOD, 16'($urandom_range(1, 65535)));
      endcase
   endtask

   task automatic run_traffic(input int count, input int unsigned idle_pct,
                              input int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_random_item();
      quiesce();
   endtask

   // Reset values of both registers; full-scale and near-zero samples.
   task automatic test_reset_defaults();
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shffff, 1'b0);
      send_sample(16'sh0001, 1'b0);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shaaaa, 1'b0);
   endtask

   // End of stream with a non-zero remainder; its sample must be ignored.
   task automatic test_end_of_stream();
      send_sample(16'sh1234, 1'b0);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh1234, 1'b0);
   endtask

   // Out-of-range volume clamps to 1 or 100; both real extremes as well.
   task automatic test_gain_clamp();
      set_gain(0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      write_register(CSR_VOLUME, 16'hff7f);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      set_gain(PERCENT_FULL);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      set_gain(1);
      send_sample(16'shc001, 1'b0);
   endtask

   // Largest, smallest and zero period; remainder must survive a zero period.
   task automatic test_period_extremes();
      set_gain(PERCENT_FULL);
      write_register(CSR_PERIOD, 16'hffff);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      write_register(CSR_PERIOD, 16'd1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh4321, 1'b0);
      write_register(CSR_PERIOD, 16'd0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      write_register(CSR_PERIOD, 16'd3);
      send_sample(16'sh0000, 1'b0);
   endtask

   // Writes to unused indexes must not disturb either register.
   task automatic test_spare_indexes();
      write_register(CSR_SPARE_LO, 16'hffff);
      write_register(CSR_SPARE_HI, 16'h0000);
      send_sample(16'sh2000, 1'b0);
   endtask

   // Long receiver hold-off while the sender keeps offering, so req_ stalls.
   task automatic test_backpressure();
      pick_random_settings();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b1;
      repeat (100) send_random_item();
      quiesce();
   endtask

   task automatic test_random_traffic();
      set_gain(PERCENT_FULL);
      write_register(CSR_PERIOD, 16'hffff);
      run_traffic(300, 0, 0);
      pick_random_settings();
      run_traffic(250, 85, 0);
      set_gain(1);
      write_register(CSR_PERIOD, 16'd1);
      run_traffic(100, 0, 85);
      pick_random_settings();
      run_traffic(150, 0, 85);
      pick_random_settings();
      run_traffic(300, 34, 34);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_end_of_stream();
      test_gain_clamp();
      test_period_extremes();
      test_spare_indexes();
      test_random_traffic();
      test_backpressure();
      quiesce();
      if (error_count == 0 && expected_duty.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
